// ===== rtl/core/gbm_pkg.sv =====
`default_nettype none

package gbm_pkg;

    // Field widths.
    localparam int GAUGE_W = 16;
    localparam int LEN_W   = 8;
    localparam int COLOR_W = 8;
    localparam int FRAC_W  = 16;
    localparam int LEVEL_W = FRAC_W + 1;

    // Level constants in Q1.16: one half, three quarters and one.
    localparam logic [LEVEL_W-1:0] Q_HALF          = 17'h08000;
    localparam logic [LEVEL_W-1:0] Q_THREE_QUARTER = 17'h0C000;
    localparam logic [LEVEL_W-1:0] Q_ONE           = 17'h10000;

    // Ramp colour constants: full scale, orange green and the green drop
    // from the green point to the orange point.
    localparam logic [24:0] COLOR_MAX    = 25'd255;
    localparam logic [24:0] ORANGE_GREEN = 25'd165;
    localparam logic [24:0] GREEN_DROP   = COLOR_MAX - ORANGE_GREEN;
    localparam logic [24:0] GREEN_TOP    = COLOR_MAX << FRAC_W;

    // Divider layout: quotient bits retired per pipeline stage.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = FRAC_W / DIV_BITS_PER_STAGE;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BAR_LENGTH = 2'd2;

    localparam logic [GAUGE_W-1:0] RANGE_LOW_RST  = 16'h0000;
    localparam logic [GAUGE_W-1:0] RANGE_HIGH_RST = 16'h7FFF;
    localparam logic [LEN_W-1:0]   BAR_LENGTH_RST = 8'd10;

    // One item's worth of work handed from front to back.
    typedef struct packed {
        logic [LEN_W-1:0]   full_leds;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] red_part;
        logic [COLOR_W-1:0] green_part;
        logic [COLOR_W-1:0] blue_part;
    } rec_t;

    // One restoring division step: returns the quotient bit over the new remainder.
    function automatic logic [FRAC_W:0] div_step(
        input logic [FRAC_W-1:0] rem,
        input logic [FRAC_W-1:0] den
    );
        logic [FRAC_W:0] shifted;
        logic [FRAC_W:0] diff;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, den};
        if (shifted >= {1'b0, den})
        begin
            div_step = {1'b1, diff[FRAC_W-1:0]};
        end
        else
        begin
            div_step = {1'b0, shifted[FRAC_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gbm_front.sv =====
`default_nettype none

module gbm_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [gbm_pkg::GAUGE_W-1:0]  gauge_value,
    input  wire logic [gbm_pkg::GAUGE_W-1:0]         range_low,
    input  wire logic [gbm_pkg::GAUGE_W-1:0]         range_high,
    input  wire logic [gbm_pkg::LEN_W-1:0]           bar_length,
    input  wire logic                                q_full,
    output logic                                     rec_valid,
    output gbm_pkg::rec_t                            rec
);

    localparam int FW = gbm_pkg::FRAC_W;
    localparam int NS = gbm_pkg::DIV_STAGES;
    localparam int CW = gbm_pkg::COLOR_W;

    logic adv;
    logic accept;

    // Stage 0: differences against the low bound.
    logic                s0_vld_reg;
    logic signed [FW:0]  s0_num_reg;
    logic signed [FW:0]  s0_den_reg;

    // Divider pipeline; index 0 is loaded by the classify stage.
    logic          dv_vld_reg  [0:NS];
    logic          dv_zero_reg [0:NS];
    logic          dv_one_reg  [0:NS];
    logic [FW-1:0] dv_rem_reg  [0:NS];
    logic [FW-1:0] dv_den_reg  [0:NS];
    logic [FW-1:0] dv_q_reg    [0:NS];
    logic [FW-1:0] dv_rem_next [0:NS-1];
    logic [FW-1:0] dv_q_next   [0:NS-1];

    // Colour and bar stage.
    logic                        c1_vld_reg;
    logic [CW-1:0]               c1_r_reg;
    logic [CW-1:0]               c1_g_reg;
    logic [CW-1:0]               c1_b_reg;
    logic [gbm_pkg::LEN_W-1:0]   c1_full_reg;
    logic [FW-1:0]               c1_frac_reg;

    // Partial LED stage.
    logic          c2_vld_reg;
    gbm_pkg::rec_t c2_rec_reg;

    logic [gbm_pkg::LEVEL_W-1:0] lvl;
    logic [gbm_pkg::LEVEL_W-1:0] off;
    logic [gbm_pkg::LEVEL_W-1:0] m;
    logic [24:0]                 prod_a;
    logic [24:0]                 prod_b;
    logic [24:0]                 prod_p;
    logic [CW-1:0]               col_r;
    logic [CW-1:0]               col_g;
    logic [CW-1:0]               col_b;
    logic [23:0]                 part_r;
    logic [23:0]                 part_g;
    logic [23:0]                 part_b;

    // The whole pipeline moves unless the last stage holds a word the queue cannot take.
    assign adv       = !c2_vld_reg || !q_full;
    assign full      = !adv;
    assign accept    = push && adv;
    assign rec_valid = c2_vld_reg;
    assign rec       = c2_rec_reg;

    // Two division steps per divider stage.
    always_comb
    begin
        logic [FW:0]   step;
        logic [FW-1:0] rem;
        logic [FW-1:0] q;
        step = '0;
        for (int k = 0; k < NS; k++)
        begin
            rem = dv_rem_reg[k];
            q   = dv_q_reg[k];
            for (int b = 0; b < gbm_pkg::DIV_BITS_PER_STAGE; b++)
            begin
                step = gbm_pkg::div_step(rem, dv_den_reg[k]);
                rem  = step[FW-1:0];
                q    = {q[FW-2:0], step[FW]};
            end
            dv_rem_next[k] = rem;
            dv_q_next[k]   = q;
        end
    end

    // Level selects a segment of the ramp; the bar position is level times length.
    always_comb
    begin
        if (dv_zero_reg[NS])
        begin
            lvl = '0;
        end
        else if (dv_one_reg[NS])
        begin
            lvl = gbm_pkg::Q_ONE;
        end
        else
        begin
            lvl = {1'b0, dv_q_reg[NS]};
        end

        off    = '0;
        m      = '0;
        prod_a = '0;
        prod_b = '0;
        col_r  = '0;
        col_g  = '0;
        col_b  = '0;
        if (lvl <= gbm_pkg::Q_HALF)
        begin
            m      = {lvl[FW-1:0], 1'b0};
            prod_a = 25'(m) * gbm_pkg::COLOR_MAX;
            prod_b = 25'(gbm_pkg::Q_ONE - m) * gbm_pkg::COLOR_MAX;
            col_g  = prod_a[23:16];
            col_b  = prod_b[23:16];
        end
        else if (lvl <= gbm_pkg::Q_THREE_QUARTER)
        begin
            off    = lvl - gbm_pkg::Q_HALF;
            m      = {off[FW-2:0], 2'b00};
            prod_a = 25'(m) * gbm_pkg::COLOR_MAX;
            prod_b = gbm_pkg::GREEN_TOP - 25'(m) * gbm_pkg::GREEN_DROP;
            col_r  = prod_a[23:16];
            col_g  = prod_b[23:16];
        end
        else
        begin
            off    = lvl - gbm_pkg::Q_THREE_QUARTER;
            m      = {off[FW-2:0], 2'b00};
            prod_b = 25'(gbm_pkg::Q_ONE - m) * gbm_pkg::ORANGE_GREEN;
            col_r  = gbm_pkg::COLOR_MAX[CW-1:0];
            col_g  = prod_b[23:16];
        end

        prod_p = 25'(lvl) * 25'(bar_length);
    end

    // The partial LED takes each channel scaled by the fractional remainder.
    assign part_r = 24'(c1_r_reg) * 24'(c1_frac_reg);
    assign part_g = 24'(c1_g_reg) * 24'(c1_frac_reg);
    assign part_b = 24'(c1_b_reg) * 24'(c1_frac_reg);

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg    <= accept;
            dv_vld_reg[0] <= s0_vld_reg;
            for (int k = 0; k < NS; k++)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            c1_vld_reg <= dv_vld_reg[NS];
            c2_vld_reg <= c1_vld_reg;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_num_reg <= $signed({gauge_value[FW-1], gauge_value} - {range_low[FW-1], range_low});
            s0_den_reg <= $signed({range_high[FW-1], range_high} - {range_low[FW-1], range_low});

            // Classify: empty bar, full bar, or a real division with num below den.
            dv_zero_reg[0] <= (s0_den_reg <= 0) || (s0_num_reg <= 0);
            dv_one_reg[0]  <= s0_num_reg >= s0_den_reg;
            dv_rem_reg[0]  <= s0_num_reg[FW-1:0];
            dv_den_reg[0]  <= s0_den_reg[FW-1:0];
            dv_q_reg[0]    <= '0;

            for (int k = 0; k < NS; k++)
            begin
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_one_reg[k+1]  <= dv_one_reg[k];
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_q_reg[k+1]    <= dv_q_next[k];
            end

            c1_r_reg    <= col_r;
            c1_g_reg    <= col_g;
            c1_b_reg    <= col_b;
            c1_full_reg <= prod_p[23:16];
            c1_frac_reg <= prod_p[FW-1:0];

            c2_rec_reg.full_leds  <= c1_full_reg;
            c2_rec_reg.red        <= c1_r_reg;
            c2_rec_reg.green      <= c1_g_reg;
            c2_rec_reg.blue       <= c1_b_reg;
            c2_rec_reg.red_part   <= part_r[23:16];
            c2_rec_reg.green_part <= part_g[23:16];
            c2_rec_reg.blue_part  <= part_b[23:16];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gbm_queue.sv =====
`default_nettype none

module gbm_queue #(
    parameter int DEPTH = gbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire gbm_pkg::rec_t wr_rec,
    output logic               q_full,
    input  wire logic          rd_en,
    output gbm_pkg::rec_t      rd_rec,
    output logic               q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbm_pkg::rec_t    store [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_rec  = store[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gbm_back.sv =====
`default_nettype none

module gbm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire gbm_pkg::rec_t                 q_rec,
    output logic                               q_pop,
    input  wire logic [gbm_pkg::LEN_W-1:0]     bar_length,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [gbm_pkg::LEN_W-1:0]          start_led,
    output logic [gbm_pkg::LEN_W-1:0]          led_count,
    output logic [gbm_pkg::COLOR_W-1:0]        red,
    output logic [gbm_pkg::COLOR_W-1:0]        green,
    output logic [gbm_pkg::COLOR_W-1:0]        blue,
    output logic                               last_command
);

    localparam int LW = gbm_pkg::LEN_W;

    logic          out_vld_reg;
    logic          phase_reg;
    logic          load;
    logic [LW-1:0] start_max;
    logic [LW-1:0] full_count;
    logic [LW-1:0] part_start;
    logic [LW-1:0] start_led_reg;
    logic [LW-1:0] led_count_reg;
    logic [gbm_pkg::COLOR_W-1:0] red_reg;
    logic [gbm_pkg::COLOR_W-1:0] green_reg;
    logic [gbm_pkg::COLOR_W-1:0] blue_reg;
    logic          last_reg;

    // The output register takes a new word when it is free or being drained.
    assign load  = !q_empty && (!out_vld_reg || pop);
    assign q_pop = load && phase_reg;
    assign empty = !out_vld_reg;

    // Clamp start to the last LED and count to the bar length.
    assign start_max  = (bar_length == '0) ? '0 : bar_length - 1'b1;
    assign full_count = (q_rec.full_leds > bar_length) ? bar_length : q_rec.full_leds;
    assign part_start = (q_rec.full_leds > start_max) ? start_max : q_rec.full_leds;

    assign start_led    = start_led_reg;
    assign led_count    = led_count_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last_command = last_reg;

    // Word sequencer: full-bar command first, then the partial LED.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_vld_reg <= 1'b1;
                phase_reg   <= !phase_reg;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!phase_reg)
            begin
                start_led_reg <= '0;
                led_count_reg <= full_count;
                red_reg       <= q_rec.red;
                green_reg     <= q_rec.green;
                blue_reg      <= q_rec.blue;
                last_reg      <= 1'b0;
            end
            else
            begin
                start_led_reg <= part_start;
                led_count_reg <= (bar_length == '0) ? '0 : LW'(1);
                red_reg       <= q_rec.red_part;
                green_reg     <= q_rec.green_part;
                blue_reg      <= q_rec.blue_part;
                last_reg      <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gradient_bar_graph_mapper_unit.sv =====
// Pipeline: a word accepted passes 2 input stages, 8 divider stages, 2 colour stages,
// the queue and the output register before its first result word shows.
// Throughput: the gauge word rate is bounded by the two result words per item leaving
// through the single result port; the divider takes one word a cycle unless stalled.
// Reset: rst_n clears all valid bits, pointers and the sequencer at once and loads the
// configuration registers with their defaults; there is no clearing pass.
`default_nettype none

module gradient_bar_graph_mapper_unit #(
    parameter int QUEUE_DEPTH = gbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [3:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [gbm_pkg::GAUGE_W-1:0]  gauge_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [gbm_pkg::LEN_W-1:0]                start_led,
    output logic [gbm_pkg::LEN_W-1:0]                led_count,
    output logic [gbm_pkg::COLOR_W-1:0]              red,
    output logic [gbm_pkg::COLOR_W-1:0]              green,
    output logic [gbm_pkg::COLOR_W-1:0]              blue,
    output logic                                     last_command
);

    logic [gbm_pkg::GAUGE_W-1:0] range_low_reg;
    logic [gbm_pkg::GAUGE_W-1:0] range_high_reg;
    logic [gbm_pkg::LEN_W-1:0]   bar_length_reg;
    logic                        cfg_wr;

    logic          rec_valid;
    gbm_pkg::rec_t rec;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    gbm_pkg::rec_t q_rec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= gbm_pkg::RANGE_LOW_RST;
            range_high_reg <= gbm_pkg::RANGE_HIGH_RST;
            bar_length_reg <= gbm_pkg::BAR_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                gbm_pkg::REG_RANGE_LOW:  range_low_reg  <= pwdata[15:0];
                gbm_pkg::REG_RANGE_HIGH: range_high_reg <= pwdata[15:0];
                gbm_pkg::REG_BAR_LENGTH: bar_length_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back; signed bounds come back sign-extended.
    always_comb
    begin
        case (paddr[3:2])
            gbm_pkg::REG_RANGE_LOW:  prdata = {{16{range_low_reg[15]}}, range_low_reg};
            gbm_pkg::REG_RANGE_HIGH: prdata = {{16{range_high_reg[15]}}, range_high_reg};
            gbm_pkg::REG_BAR_LENGTH: prdata = {24'd0, bar_length_reg};
            default:                 prdata = '0;
        endcase
    end

    gbm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .gauge_value (gauge_value),
        .range_low   (range_low_reg),
        .range_high  (range_high_reg),
        .bar_length  (bar_length_reg),
        .q_full      (q_full),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    gbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_rec  (rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_rec  (q_rec),
        .q_empty (q_empty)
    );

    gbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rec        (q_rec),
        .q_pop        (q_pop),
        .bar_length   (bar_length_reg),
        .empty        (empty),
        .pop          (pop),
        .start_led    (start_led),
        .led_count    (led_count),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_command (last_command)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gbm_checker.sv =====
`default_nettype none

module gbm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] start_led,
    input wire logic [7:0] led_count,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic       last_command
);

    logic       expect_last_reg;
    logic [7:0] owed_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // Words still owed: two per accepted item, less those taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_last_reg <= 1'b0;
            owed_reg        <= '0;
        end
        else
        begin
            if (out_acc)
            begin
                expect_last_reg <= !expect_last_reg;
            end
            owed_reg <= owed_reg + (in_acc ? 8'd2 : 8'd0) - (out_acc ? 8'd1 : 8'd0);
        end
    end

    // A waiting word holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable({start_led, led_count, red, green, blue,
                                               last_command}))
        else $error("result word changed while stalled");

    // Full-bar and partial-LED words alternate, full-bar first.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> last_command == expect_last_reg)
        else $error("result words out of order");

    // No result word without an item to account for it.
    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> owed_reg != 8'd0)
        else $error("result word with no accepted item");

    // The full-bar word starts at LED zero; the partial word sets at most one LED.
    a_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_command ? (led_count <= 8'd1) : (start_led == 8'd0)))
        else $error("malformed LED command");

endmodule

bind gradient_bar_graph_mapper_unit gbm_checker u_gbm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .start_led    (start_led),
    .led_count    (led_count),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_command (last_command)
);

`default_nettype wire

// ===== bench/gradient_bar_graph_mapper_unit_test.sv =====
`default_nettype none

module gradient_bar_graph_mapper_unit_test;

    import gbm_pkg::*;

    // Q1.16 level points of the colour ramp.
    localparam int unsigned LVL_HALF  = 32'd32768;
    localparam int unsigned LVL_3QTR  = 32'd49152;
    localparam int unsigned LVL_ONE   = 32'd65536;
    localparam int unsigned FULL_SCALE = 32'd255;
    localparam int unsigned ORANGE_G   = 32'd165;

    // Idling modes of the two sides.
    localparam int MODE_NONE   = 0;
    localparam int MODE_SEND   = 1;
    localparam int MODE_RECV   = 2;
    localparam int MODE_BOTH   = 3;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 400;
    localparam int REPORT_LIMIT    = 10;

    // One LED bar command as it leaves the block.
    typedef struct packed {
        logic [LEN_W-1:0]   start_led;
        logic [LEN_W-1:0]   led_count;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last_command;
    } led_cmd_t;

    // Predicts the two LED commands of every accepted gauge word and checks
    // the commands that come out against them in order.
    class led_command_ledger;
        logic signed [GAUGE_W-1:0] range_low;
        logic signed [GAUGE_W-1:0] range_high;
        logic [LEN_W-1:0]          bar_len;
        led_cmd_t                  pending_cmds[$];
        int                        mismatches;
        int                        checked;

        function new();
            range_low  = RANGE_LOW_RST;
            range_high = RANGE_HIGH_RST;
            bar_len    = BAR_LENGTH_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_RANGE_LOW:  range_low  = value[GAUGE_W-1:0];
                REG_RANGE_HIGH: range_high = value[GAUGE_W-1:0];
                REG_BAR_LENGTH: bar_len    = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp start and count against the bar length.
        function led_cmd_t clamp_cmd(int unsigned first, int unsigned count, int unsigned r,
                                     int unsigned g, int unsigned b, logic last);
            led_cmd_t    cmd;
            int unsigned start_max;
            start_max = (bar_len > 0) ? bar_len - 1 : 0;
            cmd.start_led    = (first > start_max) ? start_max[7:0] : first[7:0];
            cmd.led_count    = (count > bar_len) ? bar_len : count[7:0];
            cmd.red          = r[7:0];
            cmd.green        = g[7:0];
            cmd.blue         = b[7:0];
            cmd.last_command = last;
            return cmd;
        endfunction

        // Map a gauge word to its level, ramp colour and bar split.
        function void note_gauge(logic signed [GAUGE_W-1:0] v);
            int          num;
            int          den;
            int unsigned lvl;
            int unsigned m;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned p;
            int unsigned lit;
            int unsigned frac;
            num = int'(v) - int'(range_low);
            den = int'(range_high) - int'(range_low);
            if (den <= 0 || num <= 0)
            begin
                lvl = 0;
            end
            else if (num >= den)
            begin
                lvl = LVL_ONE;
            end
            else
            begin
                lvl = (unsigned'(num) << 16) / unsigned'(den);
            end

            if (lvl <= LVL_HALF)
            begin
                m = 2 * lvl;
                r = 0;
                g = (FULL_SCALE * m) >> 16;
                b = (FULL_SCALE * (LVL_ONE - m)) >> 16;
            end
            else if (lvl <= LVL_3QTR)
            begin
                m = 4 * (lvl - LVL_HALF);
                r = (FULL_SCALE * m) >> 16;
                g = (FULL_SCALE * (LVL_ONE - m) + ORANGE_G * m) >> 16;
                b = 0;
            end
            else
            begin
                m = 4 * (lvl - LVL_3QTR);
                r = FULL_SCALE;
                g = (ORANGE_G * (LVL_ONE - m)) >> 16;
                b = 0;
            end

            p    = lvl * 32'(bar_len);
            lit  = p >> 16;
            frac = p & 32'hFFFF;
            pending_cmds.push_back(clamp_cmd(0, lit, r, g, b, 1'b0));
            pending_cmds.push_back(clamp_cmd(lit, 1, (r * frac) >> 16, (g * frac) >> 16,
                                             (b * frac) >> 16, 1'b1));
        endfunction

        function void check_command(led_cmd_t got);
            led_cmd_t want;
            checked++;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display({"Unexpected LED command: start %0d count %0d ",
                              "rgb %0d/%0d/%0d last %0b"},
                             got.start_led, got.led_count, got.red, got.green, got.blue,
                             got.last_command);
                end
                return;
            end
            want = pending_cmds.pop_front();
            if (got.start_led !== want.start_led || got.led_count !== want.led_count ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last_command !== want.last_command)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display({"LED command mismatch: expected start %0d count %0d ",
                              "rgb %0d/%0d/%0d last %0b"},
                             want.start_led, want.led_count, want.red, want.green, want.blue,
                             want.last_command);
                    $display({"                        actual start %0d count %0d ",
                              "rgb %0d/%0d/%0d last %0b"},
                             got.start_led, got.led_count, got.red, got.green, got.blue,
                             got.last_command);
                end
            end
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [3:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       push;
    logic                       full;
    logic signed [GAUGE_W-1:0]  gauge_value;
    logic                       empty;
    logic                       pop;
    logic [LEN_W-1:0]           start_led;
    logic [LEN_W-1:0]           led_count;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
    logic                       last_command;

    led_command_ledger ledger;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_requests = 0;
    int                words_sent = 0;
    int                settings_run = 0;

    gradient_bar_graph_mapper_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .gauge_value  (gauge_value),
        .empty        (empty),
        .pop          (pop),
        .start_led    (start_led),
        .led_count    (led_count),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_command (last_command)
    );

    always #5 clk = ~clk;

    // Give up after a generous fixed time.
    initial
    begin
        #3000000;
        $display("[gradient_bar_graph_mapper_unit] ERROR");
        $finish;
    end

    // Result side: check every popped word, then decide the next pop.
    initial
    begin
        int       hold_seen;
        int       hold_left;
        led_cmd_t got;
        hold_seen = 0;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.start_led    = start_led;
                got.led_count    = led_count;
                got.red          = red;
                got.green        = green;
                got.blue         = blue;
                got.last_command = last_command;
                ledger.check_command(got);
            end
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one gauge word and hold it until accepted, then maybe idle.
    task automatic send_gauge(input logic signed [GAUGE_W-1:0] v);
        int gap;
        push        <= 1'b1;
        gauge_value <= v;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        ledger.note_gauge(v);
        words_sent++;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Two-phase register write; the block is idle whenever this runs.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        ledger.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic signed [GAUGE_W-1:0] lo,
                                 input logic signed [GAUGE_W-1:0] hi,
                                 input logic [LEN_W-1:0] len);
        write_reg(REG_RANGE_LOW, {{16{lo[15]}}, lo});
        write_reg(REG_RANGE_HIGH, {{16{hi[15]}}, hi});
        write_reg(REG_BAR_LENGTH, {24'd0, len});
        settings_run++;
    endtask

    // Stop offering, wait for every command to come back, then let the pipe go quiet.
    task automatic settle();
        push <= 1'b0;
        while (ledger.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            MODE_SEND:
            begin
                send_idle_pct  = 50;
                recv_stall_pct = 0;
            end
            MODE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 50;
            end
            MODE_BOTH:
            begin
                send_idle_pct  = 8;
                recv_stall_pct = 8;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Random gauge word: mostly around the configured range, sometimes at its
    // edges, sometimes anywhere in the 16-bit space.
    function automatic logic signed [GAUGE_W-1:0] pick_gauge(
        input logic signed [GAUGE_W-1:0] lo,
        input logic signed [GAUGE_W-1:0] hi
    );
        int base;
        int span;
        int x;
        int pick;
        base = (lo < hi) ? int'(lo) : int'(hi);
        span = (lo < hi) ? int'(hi) - int'(lo) : int'(lo) - int'(hi);
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            return GAUGE_W'($urandom_range(65535));
        end
        else if (pick < 35)
        begin
            x = (($urandom_range(1) == 0) ? int'(lo) : int'(hi)) + int'($urandom_range(2)) - 1;
        end
        else
        begin
            if (span == 0)
            begin
                span = 2000;
            end
            x = base - span / 4 + int'($urandom_range(span + span / 2));
        end
        if (x < -32768)
        begin
            x = -32768;
        end
        if (x > 32767)
        begin
            x = 32767;
        end
        return x[15:0];
    endfunction

    // Stimulus: directed corners, then random phases over several settings.
    initial
    begin
        logic signed [GAUGE_W-1:0] lo;
        logic signed [GAUGE_W-1:0] hi;
        logic signed [GAUGE_W-1:0] tmp;
        logic [LEN_W-1:0]          len;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        push        <= 1'b0;
        gauge_value <= '0;
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: below low, at low, tiny level, half, about three quarters and at full.
        set_idling(MODE_NONE);
        send_gauge(-16'sd32768);
        send_gauge(16'sd0);
        send_gauge(16'sd1);
        send_gauge(16'sd16384);
        send_gauge(16'sd24575);
        send_gauge(16'sd32767);
        settle();

        // Widest range and longest bar.
        apply_setting(-16'sd32768, 16'sd32767, 8'd255);
        send_gauge(-16'sd32768);
        send_gauge(16'sd0);
        send_gauge(16'sd16383);
        send_gauge(16'sd32767);
        send_gauge(16'sh55AA);
        settle();

        // High equal to low, then high below low: the level is zero.
        apply_setting(16'sd100, 16'sd100, 8'd7);
        send_gauge(16'sd100);
        send_gauge(16'sd32767);
        settle();
        apply_setting(16'sd20, -16'sd20, 8'd7);
        send_gauge(16'sd0);
        settle();

        // Zero bar length: both commands clamp start and count to zero.
        apply_setting(-16'sd1000, 16'sd1000, 8'd0);
        send_gauge(-16'sd2000);
        send_gauge(16'sd0);
        send_gauge(16'sd2000);
        settle();

        // Single LED over a one-step range.
        apply_setting(16'sd0, 16'sd1, 8'd1);
        send_gauge(16'sd0);
        send_gauge(16'sd1);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = -16'sd32768;
                    hi = 16'sd32767;
                    len = 8'd255;
                end
                1:
                begin
                    lo = -16'sd500;
                    hi = 16'sd1500;
                    len = 8'd10;
                end
                2:
                begin
                    lo = 16'sd1000;
                    hi = -16'sd1000;
                    len = 8'd20;
                end
                3:
                begin
                    lo = 16'sd0;
                    hi = 16'sd200;
                    len = 8'd1;
                end
                default:
                begin
                    lo = GAUGE_W'($urandom_range(65535));
                    hi = GAUGE_W'($urandom_range(65535));
                    if (lo > hi && $urandom_range(9) != 0)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    len = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                end
            endcase
            apply_setting(lo, hi, len);
            set_idling(phase % 4);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Long receiver hold-off while words keep coming, to fill the block.
                if (phase == 0 && i == 50)
                begin
                    hold_requests++;
                end
                send_gauge(pick_gauge(lo, hi));
            end
            settle();
        end

        $display("Sent %0d gauge words over %0d register settings and checked %0d LED commands,",
                 words_sent, settings_run, ledger.checked);
        $display("with idle, stall and long backpressure phases on both sides.");
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
        begin
            $display("[gradient_bar_graph_mapper_unit] OK");
        end
        else
        begin
            $display("Failures: %0d mismatched or unexpected, %0d missing",
                     ledger.mismatches, ledger.outstanding());
            $display("[gradient_bar_graph_mapper_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
